/* design/idl_lex_pkg.sv */
package idl_lex_pkg;

  // width of the position and length fields on the result side
  localparam int RecW = 16;
  localparam int MaxRes = 4;
  localparam int KwBuf = 9;

  // result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // token types
  localparam logic [5:0] T_IDENT    = 6'd0;
  localparam logic [5:0] T_INT      = 6'd17;
  localparam logic [5:0] T_FLOAT    = 6'd18;
  localparam logic [5:0] T_STRING   = 6'd19;
  localparam logic [5:0] T_SYM_BASE = 6'd20;
  localparam logic [5:0] T_DOT      = 6'd31;
  localparam logic [5:0] T_END      = 6'd36;

  // error codes
  localparam logic ERR_UNEXPECTED = 1'b0;
  localparam logic ERR_UNTERM     = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_SLASH,
    MODE_DOT,
    MODE_COMMENT
  } scan_mode_e;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } lex_in_t;

  typedef struct packed {
    logic [1:0]      rec_kind;
    logic [7:0]      text_byte;
    logic [5:0]      token_type;
    logic            err_code;
    logic [RecW-1:0] first_line;
    logic [RecW-1:0] start_column;
    logic [RecW-1:0] token_length;
    logic            last_of_run;
  } lex_out_t;

  // all results of one input beat
  typedef struct packed {
    lex_out_t [MaxRes-1:0] recs;
    logic [2:0]            cnt;
  } lex_grp_t;

endpackage

/* design/idl_lex_front.sv */
module idl_lex_front import idl_lex_pkg::*; #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  lex_in_t  in_i,
  output logic     wr_o,
  output lex_grp_t grp_o
);

  localparam logic [LINE_WIDTH-1:0]   LineMax = '1;
  localparam logic [COLUMN_WIDTH-1:0] ColMax  = '1;
  localparam logic [LENGTH_WIDTH-1:0] LenMax  = '1;
  localparam int KwW = 8 * KwBuf;

  localparam logic [KwW-1:0] KwText [16] = '{
    KwW'("namespace"), KwW'("struct"), KwW'("bool"), KwW'("int8"),
    KwW'("uint8"), KwW'("int16"), KwW'("uint16"), KwW'("int32"),
    KwW'("uint32"), KwW'("int64"), KwW'("uint64"), KwW'("float32"),
    KwW'("float64"), KwW'("string"), KwW'("vector"), KwW'("array")
  };
  localparam int KwLen [16] = '{9, 6, 4, 4, 5, 5, 6, 5, 6, 5, 6, 7, 7, 6, 6, 5};

  function automatic logic alpha_chr(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic digit_chr(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  // bit 4 set when the byte is a symbol, low bits give its index
  function automatic logic [4:0] sym_code(logic [7:0] b);
    logic [4:0] r;
    case (b)
      "{":     r = 5'h10;
      "}":     r = 5'h11;
      "[":     r = 5'h12;
      "]":     r = 5'h13;
      "(":     r = 5'h14;
      ")":     r = 5'h15;
      "<":     r = 5'h16;
      ">":     r = 5'h17;
      ",":     r = 5'h18;
      ";":     r = 5'h19;
      ":":     r = 5'h1a;
      ".":     r = 5'h1b;
      "&":     r = 5'h1c;
      "*":     r = 5'h1d;
      "?":     r = 5'h1e;
      "=":     r = 5'h1f;
      default: r = 5'h00;
    endcase
    return r;
  endfunction

  // keyword lookup over the last identifier bytes
  function automatic logic [5:0] ident_type(logic [LENGTH_WIDTH-1:0] n,
                                            logic [KwW-1:0] kw);
    logic [5:0] t;
    t = T_IDENT;
    for (int k = 0; k < 16; k++) begin
      if (n == LENGTH_WIDTH'(KwLen[k]) &&
          (kw & ((KwW'(1) << (8 * KwLen[k])) - KwW'(1))) == KwText[k]) begin
        t = 6'(k + 1);
      end
    end
    return t;
  endfunction

  function automatic scan_mode_e start_mode(logic [7:0] b);
    scan_mode_e m;
    if (b == "/") begin
      m = MODE_SLASH;
    end else if (b == ".") begin
      m = MODE_DOT;
    end else if (alpha_chr(b) || b == "_") begin
      m = MODE_IDENT;
    end else if (digit_chr(b)) begin
      m = MODE_NUMBER;
    end else if (b == 8'h22) begin
      m = MODE_STRING;
    end else begin
      m = MODE_IDLE;
    end
    return m;
  endfunction

  function automatic lex_out_t mk(logic [1:0] kind, logic [7:0] ch, logic [5:0] typ,
                                  logic err, logic [RecW-1:0] ln,
                                  logic [RecW-1:0] cl, logic [RecW-1:0] len);
    lex_out_t r;
    r.rec_kind     = kind;
    r.text_byte    = ch;
    r.token_type   = typ;
    r.err_code     = err;
    r.first_line   = ln;
    r.start_column = cl;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  scan_mode_e mode_q, mode_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d, tline_q, tline_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d, tcol_q, tcol_d;
  logic [LENGTH_WIDTH-1:0] tcnt_q, tcnt_d;
  logic                    fs_q, fs_d, ej_q, ej_d;
  logic [KwW-1:0]          kw_q, kw_d;

  logic [7:0] b;
  assign b = in_i.in_byte;

  // next scan mode
  always_comb begin
    mode_d = mode_q;
    if (acc_i) begin
      if (in_i.func) begin
        mode_d = MODE_IDLE;
      end else begin
        unique case (mode_q)
          MODE_IDENT: begin
            mode_d = (alpha_chr(b) || digit_chr(b) || b == "_") ? MODE_IDENT : start_mode(b);
          end
          MODE_NUMBER: begin
            if ((ej_q && (b == "+" || b == "-")) || digit_chr(b) || b == "_" ||
                (b == "." && !fs_q) || b == "e" || b == "E") begin
              mode_d = MODE_NUMBER;
            end else begin
              mode_d = start_mode(b);
            end
          end
          MODE_STRING: begin
            if (b == 8'h22 || b == 8'h0a) begin
              mode_d = MODE_IDLE;
            end else if (b == 8'h5c) begin
              mode_d = MODE_ESCAPE;
            end else begin
              mode_d = MODE_STRING;
            end
          end
          MODE_ESCAPE: mode_d = MODE_STRING;
          MODE_SLASH:  mode_d = (b == "/") ? MODE_COMMENT : start_mode(b);
          MODE_DOT:    mode_d = digit_chr(b) ? MODE_NUMBER : start_mode(b);
          MODE_COMMENT: mode_d = (b == 8'h0a) ? MODE_IDLE : MODE_COMMENT;
          default:     mode_d = start_mode(b);
        endcase
      end
    end
  end

  // results and token bookkeeping
  lex_out_t [MaxRes-1:0] recs;
  logic [1:0]            n;
  logic                  do_start;
  logic [4:0]            sc;
  logic [7:0]            esc;

  always_comb begin
    recs     = '0;
    n        = '0;
    do_start = 1'b0;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    tcnt_d   = tcnt_q;
    fs_d     = fs_q;
    ej_d     = ej_q;
    kw_d     = kw_q;
    sc       = sym_code(b);
    case (b)
      "n":     esc = 8'h0a;
      "t":     esc = 8'h09;
      "r":     esc = 8'h0d;
      default: esc = b;
    endcase
    if (acc_i && in_i.func) begin
      // flush open token, then the end token
      unique case (mode_q)
        MODE_IDENT: begin
          recs[n] = mk(KIND_TOKEN, 8'h00, ident_type(tcnt_q, kw_q), 1'b0,
                       RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
          n = n + 2'd1;
        end
        MODE_NUMBER: begin
          recs[n] = mk(KIND_TOKEN, 8'h00, fs_q ? T_FLOAT : T_INT, 1'b0,
                       RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
          n = n + 2'd1;
        end
        MODE_ESCAPE: begin
          recs[n] = mk(KIND_TEXT, 8'h5c, T_IDENT, 1'b0, '0, '0, '0);
          n = n + 2'd1;
          if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
          recs[n] = mk(KIND_TOKEN, 8'h00, T_STRING, 1'b0,
                       RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_d));
          n = n + 2'd1;
        end
        MODE_STRING: begin
          recs[n] = mk(KIND_TOKEN, 8'h00, T_STRING, 1'b0,
                       RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
          n = n + 2'd1;
        end
        MODE_SLASH: begin
          recs[n] = mk(KIND_ERROR, "/", T_IDENT, ERR_UNEXPECTED,
                       RecW'(tline_q), RecW'(tcol_q), '0);
          n = n + 2'd1;
        end
        MODE_DOT: begin
          recs[n] = mk(KIND_TOKEN, ".", T_DOT, 1'b0,
                       RecW'(tline_q), RecW'(tcol_q), RecW'(1));
          n = n + 2'd1;
        end
        default: ;
      endcase
      recs[n] = mk(KIND_TOKEN, 8'h00, T_END, 1'b0, RecW'(line_q), RecW'(col_q), '0);
      n = n + 2'd1;
      fs_d = 1'b0;
      ej_d = 1'b0;
    end else if (acc_i) begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (alpha_chr(b) || digit_chr(b) || b == "_") begin
            kw_d = {kw_d[KwW-9:0], b};
            recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
            n = n + 2'd1;
            if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
          end else begin
            recs[n] = mk(KIND_TOKEN, 8'h00, ident_type(tcnt_q, kw_q), 1'b0,
                         RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (ej_q && (b == "+" || b == "-")) begin
            ej_d = 1'b0;
            recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
            n = n + 2'd1;
            if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
          end else begin
            ej_d = 1'b0;
            if (digit_chr(b) || b == "_" || (b == "." && !fs_q) || b == "e" || b == "E") begin
              if (b == ".") fs_d = 1'b1;
              if (b == "e" || b == "E") ej_d = 1'b1;
              recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
              n = n + 2'd1;
              if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
            end else begin
              recs[n] = mk(KIND_TOKEN, 8'h00, fs_q ? T_FLOAT : T_INT, 1'b0,
                           RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
              n = n + 2'd1;
              do_start = 1'b1;
            end
          end
        end
        MODE_STRING: begin
          if (b == 8'h22) begin
            recs[n] = mk(KIND_TOKEN, 8'h00, T_STRING, 1'b0,
                         RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
            n = n + 2'd1;
          end else if (b == 8'h0a) begin
            recs[n] = mk(KIND_ERROR, 8'h00, T_IDENT, ERR_UNTERM,
                         RecW'(line_q), RecW'(col_q), '0);
            n = n + 2'd1;
            recs[n] = mk(KIND_TOKEN, 8'h00, T_STRING, 1'b0,
                         RecW'(tline_q), RecW'(tcol_q), RecW'(tcnt_q));
            n = n + 2'd1;
          end else if (b != 8'h5c) begin
            recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
            n = n + 2'd1;
            if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
          end
        end
        MODE_ESCAPE: begin
          recs[n] = mk(KIND_TEXT, esc, T_IDENT, 1'b0, '0, '0, '0);
          n = n + 2'd1;
          if (tcnt_d != LenMax) tcnt_d = tcnt_d + 1'b1;
        end
        MODE_SLASH: begin
          if (b != "/") begin
            recs[n] = mk(KIND_ERROR, "/", T_IDENT, ERR_UNEXPECTED,
                         RecW'(tline_q), RecW'(tcol_q), '0);
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        MODE_DOT: begin
          if (digit_chr(b)) begin
            // leading dot number
            fs_d   = 1'b1;
            ej_d   = 1'b0;
            recs[n] = mk(KIND_TEXT, ".", T_IDENT, 1'b0, '0, '0, '0);
            n = n + 2'd1;
            recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
            n = n + 2'd1;
            tcnt_d = LENGTH_WIDTH'(2);
          end else begin
            recs[n] = mk(KIND_TOKEN, ".", T_DOT, 1'b0,
                         RecW'(tline_q), RecW'(tcol_q), RecW'(1));
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        MODE_COMMENT: ;
        default: do_start = 1'b1;
      endcase

      // a new token begins at this byte
      if (do_start && !is_blank(b)) begin
        tline_d = line_q;
        tcol_d  = col_q;
        tcnt_d  = '0;
        if (alpha_chr(b) || b == "_" || digit_chr(b)) begin
          if (digit_chr(b)) begin
            fs_d = 1'b0;
            ej_d = 1'b0;
          end else begin
            kw_d = {kw_d[KwW-9:0], b};
          end
          recs[n] = mk(KIND_TEXT, b, T_IDENT, 1'b0, '0, '0, '0);
          n = n + 2'd1;
          tcnt_d = LENGTH_WIDTH'(1);
        end else if (b != "/" && b != "." && b != 8'h22) begin
          if (sc[4]) begin
            recs[n] = mk(KIND_TOKEN, b, T_SYM_BASE + 6'(sc[3:0]), 1'b0,
                         RecW'(line_q), RecW'(col_q), RecW'(1));
          end else begin
            recs[n] = mk(KIND_ERROR, b, T_IDENT, ERR_UNEXPECTED,
                         RecW'(line_q), RecW'(col_q), '0);
          end
          n = n + 2'd1;
        end
      end
    end
    if (n != 2'd0) recs[n - 2'd1].last_of_run = 1'b1;
  end

  assign wr_o       = acc_i && (n != 2'd0);
  assign grp_o.recs = recs;
  assign grp_o.cnt  = {1'b0, n};

  // position tracking
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (acc_i) begin
      if (in_i.func) begin
        line_d = LINE_WIDTH'(1);
        col_d  = COLUMN_WIDTH'(1);
      end else if (b == 8'h0a) begin
        if (line_q != LineMax) line_d = line_q + 1'b1;
        col_d = COLUMN_WIDTH'(1);
      end else if (col_q != ColMax) begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= LINE_WIDTH'(1);
      col_q   <= COLUMN_WIDTH'(1);
      tline_q <= LINE_WIDTH'(1);
      tcol_q  <= COLUMN_WIDTH'(1);
      tcnt_q  <= '0;
      fs_q    <= 1'b0;
      ej_q    <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      tcnt_q  <= tcnt_d;
      fs_q    <= fs_d;
      ej_q    <= ej_d;
    end
  end

  // keyword shift buffer
  always_ff @(posedge clk_i) begin
    kw_q <= kw_d;
  end

endmodule

/* design/idl_lex_back.sv */
module idl_lex_back import idl_lex_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  lex_grp_t grp_i,
  output logic     full_o,
  output logic     empty_o,
  input  logic     pop_i,
  output lex_out_t out_o
);

  localparam int QDepth = 4;
  localparam int PtrW = $clog2(QDepth);

  lex_grp_t        mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic [1:0]      sub_q;
  logic            pop_beat, head_done;

  assign full_o    = cnt_q == (PtrW + 1)'(QDepth);
  assign empty_o   = cnt_q == '0;
  assign out_o     = mem_q[rptr_q].recs[sub_q];
  assign pop_beat  = pop_i && !empty_o;
  assign head_done = pop_beat && (sub_q == 2'(mem_q[rptr_q].cnt - 3'd1));

  // group storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= grp_i;
  end

  // pointers and record index within the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      sub_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (head_done) begin
        rptr_q <= rptr_q + 1'b1;
        sub_q  <= '0;
      end else if (pop_beat) begin
        sub_q <= sub_q + 2'd1;
      end
      if (wr_i && !head_done) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i && head_done) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/idl_token_lexer.sv */
// streaming lexer for a small interface-definition language
// input queue side: push_i / full_o, one beat per source byte or end marker;
//   a beat is taken when push_i is high and full_o is low
// result queue side: empty_o / pop_i; the oldest record sits on out_o while
//   empty_o is low and leaves when pop_i is high
// each input beat gives zero to three records; the last carries last_of_run
// the front classifies one byte per cycle while full_o is low and writes all
//   records of that byte as one group into a four-group queue; the back
//   hands them out one record per pop
// records are registered in the queue and reach out_o behind older records
// throughput: one input byte per cycle while the queue has room; the output
//   side drains one record per cycle while pop_i is high, so bursts of
//   multi-record bytes fill the queue and then full_o holds the source back
// reset clears the scan state, position to line 1 column 1, and the queue
// when the receiver stalls, records stay in the queue and full_o rises
//   once four groups are waiting
module idl_token_lexer import idl_lex_pkg::*; #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  lex_in_t  in_i,
  output logic     empty_o,
  input  logic     pop_i,
  output lex_out_t out_o
);

  logic     acc;
  logic     grp_wr;
  lex_grp_t grp;

  assign acc = push_i && !full_o;

  idl_lex_front #(
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .in_i  (in_i),
    .wr_o  (grp_wr),
    .grp_o (grp)
  );

  idl_lex_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (grp_wr),
    .grp_i  (grp),
    .full_o (full_o),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !grp_wr) else $error("group written while queue full");
  a_end_marks_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.func |-> grp_wr) else $error("end of source gave no records");
  a_grp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_wr |-> grp.recs[2'(grp.cnt - 3'd1)].last_of_run)
    else $error("group without last record mark");
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> out_o.rec_kind != 2'd3) else $error("bad record kind");
`endif

endmodule
